@@ hw/rtl/citi_pkg.sv @@
`timescale 1ns / 1ps
package citi_pkg;
  typedef enum logic [1:0] {
    OP_LOAD_REAL = 2'd0,
    OP_LOAD_IMAG = 2'd1,
    OP_QUERY     = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  localparam logic [1:0] STATUS_INSIDE = 2'd0;
  localparam logic [1:0] STATUS_BELOW  = 2'd1;
  localparam logic [1:0] STATUS_ABOVE  = 2'd2;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  localparam logic [2:0] REG_RCOUNT_ADDR = 3'd0;
  localparam logic [2:0] REG_ICOUNT_ADDR = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  entry_index;
    logic [31:0] wavelength;
    logic [31:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] real_part;
    logic [31:0] imag_part;
    logic [1:0]  real_range_status;
    logic [1:0]  imag_range_status;
  } out_item_t;
endpackage

@@ hw/rtl/complex_index_table_interpolator.sv @@
`timescale 1ns / 1ps
// Loads write the addressed table entry and leave the block idle. A query looks up the real
// table and then the imaginary table, each by a linear scan of the table memory (one entry
// read per cycle through the single read port), followed by a restoring divide unless it ends above
// range or finds no pair; the result strobe comes in the cycle after busy_o was last high.
// result_valid_o pulses for one cycle; the receiver cannot stall.
// Reset (async, active low) clears control and sets both point counts to 2;
// table contents are undefined until written.
module complex_index_table_interpolator #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  citi_pkg::in_item_t   item_i,
  output logic                 result_valid_o,
  output citi_pkg::out_item_t  result_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import citi_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_FIRST, S_SCAN, S_PAIR, S_DIV, S_DONE
  } state_e;

  // memories: index 0 real, 1 imaginary; each entry {wavelength, value}
  logic [63:0] mem_r [TABLE_DEPTH];
  logic [63:0] mem_i [TABLE_DEPTH];
  logic [63:0] rd_q;

  logic [8:0]  rcount_q, icount_q;
  state_e      state_q;
  logic        tab_q;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] last_q;
  logic [31:0] w_q, l0_q, v0_q, pl_q, pv_q;
  logic [63:0] num_q, quo_q;
  logic [64:0] rem_q;
  logic [31:0] den_q, base_q;
  logic        neg_q, below_q;
  logic [6:0]  cnt_q;
  logic [31:0] rpart_q;
  logic [1:0]  rstat_q, cur_stat_q;
  logic        first_pair_q;

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr)
      REG_RCOUNT_ADDR: prdata = {23'd0, rcount_q};
      REG_ICOUNT_ADDR: prdata = {23'd0, icount_q};
      default:         prdata = '0;
    endcase
  end

  function automatic logic [AW-1:0] eff_last(input logic [8:0] c);
    int n;
    n = int'(c);
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return AW'(n - 1);
  endfunction

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);

  logic load_ok;
  assign load_ok = accept && (32'(item_i.entry_index) < 32'(TABLE_DEPTH));

  logic [31:0] rd_l, rd_v;
  assign rd_l = rd_q[63:32];
  assign rd_v = rd_q[31:0];

  logic [AW-1:0] raddr;
  logic          rtab;
  always_comb begin
    raddr = addr_q;
    rtab  = tab_q;
    if (accept) begin
      raddr = '0;
      rtab  = 1'b0;
    end else if (state_q == S_DONE && !tab_q) begin
      raddr = '0;
      rtab  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok && item_i.opcode == OP_LOAD_REAL)
      mem_r[AW'(item_i.entry_index)] <= {item_i.wavelength, item_i.table_value};
    if (load_ok && item_i.opcode == OP_LOAD_IMAG)
      mem_i[AW'(item_i.entry_index)] <= {item_i.wavelength, item_i.table_value};
    rd_q <= rtab ? mem_i[raddr] : mem_r[raddr];
  end

  logic [64:0] trial;
  assign trial = {rem_q[63:0], num_q[63]} - {33'd0, den_q};

  logic [31:0] part;
  always_comb begin
    if (cur_stat_q == STATUS_BELOW) part = num_q[31:0];
    else if (cur_stat_q == STATUS_ABOVE || below_q == 1'b0 && den_q == 32'd1
             && num_q == 64'd0 && first_pair_q) part = base_q;
    else if (neg_q) part = (num_q > 64'(base_q)) ? 32'd0 : base_q - num_q[31:0];
    else part = (65'(base_q) + 65'(num_q) > 65'h0FFFF_FFFF) ? 32'hFFFF_FFFF
                : base_q + num_q[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      rcount_q       <= 9'd2;
      icount_q       <= 9'd2;
      result_valid_o <= 1'b0;
      tab_q          <= 1'b0;
    end else begin
      result_valid_o <= (state_q == S_DONE) && tab_q;
      if (psel && penable && pwrite && pready) begin
        unique case (paddr)
          REG_RCOUNT_ADDR: rcount_q <= pwdata[8:0];
          REG_ICOUNT_ADDR: icount_q <= pwdata[8:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && item_i.opcode == OP_QUERY) begin
            w_q     <= item_i.wavelength;
            tab_q   <= 1'b0;
            addr_q  <= AW'(1);
            last_q  <= eff_last(rcount_q);
            state_q <= S_FIRST;
          end
        end
        S_FIRST: begin
          // rd_q holds entry 0
          l0_q <= rd_l; v0_q <= rd_v;
          pl_q <= rd_l; pv_q <= rd_v;
          first_pair_q <= 1'b1;
          addr_q <= addr_q + 1'b1;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          // rd_q holds entry addr_q-1, pl_q/pv_q the entry before it
          if (w_q < l0_q) begin
            below_q <= 1'b1; neg_q <= 1'b0;
            num_q <= 64'(v0_q) * 64'(w_q);
            den_q <= l0_q; base_q <= '0;
            cur_stat_q <= STATUS_BELOW;
            rem_q <= '0; cnt_q <= '0; state_q <= S_DIV;
          end else if (AW'(addr_q - 1'b1) == last_q) begin
            below_q <= 1'b0;
            if (w_q >= rd_l) begin
              cur_stat_q <= STATUS_ABOVE;
              base_q <= rd_v; num_q <= '0; den_q <= 32'd1;
              state_q <= S_DONE;
            end else if (first_pair_q && w_q >= pl_q) begin
              first_pair_q <= 1'b0;
              num_q  <= {32'd0, w_q - pl_q};
              den_q  <= rd_l - pl_q;
              base_q <= pv_q;
              neg_q  <= rd_v < pv_q;
              quo_q  <= {32'd0, rd_v < pv_q ? pv_q - rd_v : rd_v - pv_q};
              state_q <= S_PAIR;
            end else if (first_pair_q) begin
              cur_stat_q <= STATUS_INSIDE;
              base_q <= Q_ONE; num_q <= '0; den_q <= 32'd1;
              state_q <= S_DONE;
            end else begin
              state_q <= S_PAIR;
            end
          end else begin
            if (first_pair_q && w_q >= pl_q && w_q < rd_l) begin
              first_pair_q <= 1'b0;
              num_q  <= {32'd0, w_q - pl_q};
              den_q  <= rd_l - pl_q;
              base_q <= pv_q;
              neg_q  <= rd_v < pv_q;
              quo_q  <= {32'd0, rd_v < pv_q ? pv_q - rd_v : rd_v - pv_q};
            end
            pl_q <= rd_l; pv_q <= rd_v;
            addr_q <= addr_q + 1'b1;
          end
        end
        S_PAIR: begin
          // pair found earlier: multiply then divide
          num_q <= 64'(num_q[31:0]) * 64'(quo_q[31:0]);
          cur_stat_q <= STATUS_INSIDE;
          rem_q <= '0; cnt_q <= '0; state_q <= S_DIV;
        end
        S_DIV: begin
          if (!trial[64]) rem_q <= trial;
          else rem_q <= {rem_q[63:0], num_q[63]};
          num_q <= {num_q[62:0], !trial[64]};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 7'd63) state_q <= S_DONE;
        end
        default: begin // S_DONE
          if (!tab_q) begin
            rpart_q <= part; rstat_q <= cur_stat_q;
            tab_q <= 1'b1; addr_q <= AW'(1);
            last_q <= eff_last(icount_q);
            state_q <= S_FIRST;
          end else begin
            result_o <= '{real_part: rpart_q, imag_part: part,
                          real_range_status: rstat_q, imag_range_status: cur_stat_q};
            tab_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule

@@ hw/rtl/citi_checker.sv @@
`timescale 1ns / 1ps
module citi_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input citi_pkg::in_item_t item_i,
  input logic result_valid_o,
  input citi_pkg::out_item_t result_o
);
  import citi_pkg::*;
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o) else $error("result while busy");
  a_one_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("double result");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.real_range_status <= STATUS_ABOVE &&
    result_o.imag_range_status <= STATUS_ABOVE) else $error("bad status");
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o)) else $error("result without work");
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && item_i.opcode == OP_QUERY |=> busy_o)
    else $error("query beat not taken");
endmodule

bind complex_index_table_interpolator citi_checker u_citi_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .item_i(item_i), .result_valid_o(result_valid_o), .result_o(result_o)
);
